// ===== sv/rsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsd_pkg: shared types and constants of the run-length stream decoder
// Holds the token phase and status codes, the stream magic and the result
// word that travels from the decode step to the output register.
// ----------------------------------------------------------------------------
package rsd_pkg;

	// Number of header bytes: four magic bytes and a 32-bit length.
	localparam int unsigned HDR_LEN = 8;
	localparam int unsigned HIDX_W  = 4;

	localparam logic [7:0] LOW7_MASK = 8'h7F;
	localparam logic [7:0] TOP_BIT   = 8'h80;

	// Decoded byte total saturates at two to the power 32.
	localparam logic [32:0] COUNT_SAT = 33'h1_0000_0000;

	// Magic bytes 'R', 'L', 'E', '1' in stream order.
	localparam logic [7:0] MAGIC [4] = '{8'h52, 8'h4C, 8'h45, 8'h31};

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_RUN    = 2'd1,
		PH_LIT    = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_BAD_HEADER = 3'd1,
		ST_TRUNC_RUN  = 3'd2,
		ST_TRUNC_LIT  = 3'd3,
		ST_MISMATCH   = 3'd4
	} status_t;

	// One input word.
	typedef struct packed {
		logic [7:0] in_byte;
		logic       last;
	} item_t;

	// One result word.
	typedef struct packed {
		logic [7:0] out_byte;
		logic [7:0] repeat_res;
		logic       done_res;
		status_t    status;
	} res_t;

endpackage

// ===== sv/rsd_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsd_in_stage: input register of the run-length stream decoder
// Captures one compressed word per cycle while not stalled and holds it
// until the decode step consumes it.
// ----------------------------------------------------------------------------
module rsd_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  rsd_pkg::item_t in_item,
	input  logic           adv,
	output logic           valid_s1,
	output rsd_pkg::item_t item_s1
);
	import rsd_pkg::*;

	// The held word leaves whenever the result side can advance.
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload is loaded on every accepted word.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== sv/rsd_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsd_decode: header check and token decode step
// Holds the stream state and, for the word in the input register, works out
// the next state and the result word in one pass of short logic.
// ----------------------------------------------------------------------------
module rsd_decode (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  rsd_pkg::item_t item_s1,
	output logic           res_valid,
	output rsd_pkg::res_t  res
);
	import rsd_pkg::*;

	logic [HIDX_W-1:0] hidx_q, hidx_d;
	logic [31:0]       expected_q, expected_d;
	logic [32:0]       count_q, count_d;
	phase_t            phase_q, phase_d;
	logic [7:0]        lit_rem_q, lit_rem_d;
	logic [7:0]        run_len_q, run_len_d;
	logic              bad_q, bad_d;

	logic [7:0]  b;
	logic [7:0]  len;
	logic [7:0]  add_n;
	logic [32:0] sum;
	logic        have;

	assign b   = item_s1.in_byte;
	assign len = (b & LOW7_MASK) + 8'd1;
	assign sum = count_q + {25'd0, add_n};

	// Next state and result for the word in the input register.
	always_comb begin
		hidx_d     = hidx_q;
		expected_d = expected_q;
		phase_d    = phase_q;
		lit_rem_d  = lit_rem_q;
		run_len_d  = run_len_q;
		bad_d      = bad_q;
		add_n      = 8'd0;
		have       = 1'b0;
		res.out_byte   = 8'd0;
		res.repeat_res = 8'd0;
		res.done_res   = item_s1.last;
		res.status     = ST_OK;

		if (bad_q) begin
			// Bytes after a bad header are dropped until the last one.
		end else if (!hidx_q[HIDX_W-1]) begin
			if (!hidx_q[2]) begin
				if (b != MAGIC[hidx_q[1:0]]) begin
					bad_d = 1'b1;
				end
			end else begin
				expected_d[{hidx_q[1:0], 3'b000} +: 8] =
					expected_q[{hidx_q[1:0], 3'b000} +: 8] | b;
			end
			hidx_d = hidx_q + 4'd1;
		end else begin
			unique case (phase_q)
				PH_HEADER: begin
					if ((b & TOP_BIT) != 8'd0) begin
						run_len_d = len;
						phase_d   = PH_RUN;
					end else begin
						lit_rem_d = len;
						phase_d   = PH_LIT;
					end
				end
				PH_RUN: begin
					have           = 1'b1;
					res.out_byte   = b;
					res.repeat_res = run_len_q;
					add_n          = run_len_q;
					run_len_d      = 8'd0;
					phase_d        = PH_HEADER;
				end
				default: begin
					have           = 1'b1;
					res.out_byte   = b;
					res.repeat_res = 8'd1;
					add_n          = 8'd1;
					if (lit_rem_q != 8'd0) begin
						lit_rem_d = lit_rem_q - 8'd1;
					end
					if (lit_rem_d == 8'd0) begin
						phase_d = PH_HEADER;
					end
				end
			endcase
		end

		// Saturate the decoded total.
		count_d = (sum > COUNT_SAT) ? COUNT_SAT : sum;

		// Final status uses the state as it stands after this word.
		if (item_s1.last) begin
			if (bad_d || !hidx_d[HIDX_W-1]) begin
				res.status = ST_BAD_HEADER;
			end else if (phase_d == PH_RUN) begin
				res.status = ST_TRUNC_RUN;
			end else if (phase_d == PH_LIT) begin
				res.status = ST_TRUNC_LIT;
			end else if (count_d != {1'b0, expected_d}) begin
				res.status = ST_MISMATCH;
			end
		end
	end

	assign res_valid = step && (have || item_s1.last);

	// Stream state; the last word returns everything to its reset value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hidx_q     <= '0;
			expected_q <= '0;
			count_q    <= '0;
			phase_q    <= PH_HEADER;
			lit_rem_q  <= '0;
			run_len_q  <= '0;
			bad_q      <= 1'b0;
		end else if (step) begin
			if (item_s1.last) begin
				hidx_q     <= '0;
				expected_q <= '0;
				count_q    <= '0;
				phase_q    <= PH_HEADER;
				lit_rem_q  <= '0;
				run_len_q  <= '0;
				bad_q      <= 1'b0;
			end else begin
				hidx_q     <= hidx_d;
				expected_q <= expected_d;
				count_q    <= count_d;
				phase_q    <= phase_d;
				lit_rem_q  <= lit_rem_d;
				run_len_q  <= run_len_d;
				bad_q      <= bad_d;
			end
		end
	end

	// A data result never carries a zero count or more than 128 repeats.
	a_repeat_range: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.done_res) |-> (res.repeat_res != 8'd0 && res.repeat_res <= 8'd128))
		else $error("data word with bad repeat count");

	// After a last word the decoder starts a fresh stream.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(step && item_s1.last) |=> (hidx_q == '0 && count_q == '0 && phase_q == PH_HEADER
		&& !bad_q))
		else $error("state not cleared after last word");

	// Tokens are only decoded once the whole header has been seen.
	a_phase_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_HEADER) |-> (hidx_q == 4'(HDR_LEN) && !bad_q))
		else $error("token phase active inside header");

	// The decoded total never passes its saturation value.
	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_SAT)
		else $error("decoded count above saturation");

endmodule

// ===== sv/rsd_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsd_out_stage: result register of the run-length stream decoder
// Holds one result word until the receiver takes it and tells the stages
// upstream when they may advance.
// ----------------------------------------------------------------------------
module rsd_out_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          res_valid,
	input  rsd_pkg::res_t res,
	output logic          adv,
	output logic          out_valid,
	input  logic          out_stall,
	output rsd_pkg::res_t res_s2
);
	import rsd_pkg::*;

	// The register can take a new word when empty or being emptied.
	assign adv = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			res_s2 <= res;
		end
	end

endmodule

// ===== sv/rle_stream_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_stream_decoder: streaming byte run-length decoder
// Checks the RLE1 magic and length header, then expands run and literal
// tokens into byte and repeat-count words with a final status.
// ----------------------------------------------------------------------------
// The decoder takes one compressed byte per clock cycle, with no gaps, as
// long as the result side keeps up. Each byte passes an input register, one
// decode step on the registered token state and a result register, and its
// result word is taken from the result register; while the result side
// stalls, the byte waits in the input register. Header bytes and token
// headers give no word except on the last byte, which always gives one
// word with done_res set and the stream status; the decoder is then ready
// for the next stream at once.
module rle_stream_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic [7:0] repeat_res,
	output logic       done_res,
	output logic [2:0] status
);
	import rsd_pkg::*;

	item_t in_item;
	item_t item_s1;
	logic  valid_s1;
	logic  adv;
	logic  step;
	logic  res_valid;
	res_t  res;
	res_t  res_s2;

	assign in_item.in_byte = in_byte;
	assign in_item.last    = last;

	// A word is decoded when it is held and the result side can advance.
	assign step = valid_s1 && adv;

	rsd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	rsd_decode u_dec (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item_s1   (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	rsd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.adv       (adv),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_s2    (res_s2)
	);

	assign out_byte   = res_s2.out_byte;
	assign repeat_res = res_s2.repeat_res;
	assign done_res   = res_s2.done_res;
	assign status     = res_s2.status;

endmodule
